// ===== rtl/core/ace_pkg.sv =====
// ----------------------------------------------------------------------------
// ace_pkg
// Shared constants, status codes and controller/datapath command types for
// the array circular list engine.
// ----------------------------------------------------------------------------
package ace_pkg;

  localparam int CAPACITY  = 16;
  localparam int DATA_BITS = 8;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // link/data read address select
  typedef enum logic [2:0] {
    RD_NONE,
    RD_HEAD,
    RD_WALK,
    RD_FREE,
    RD_PREV,
    RD_CUR
  } rd_sel_e;

  // link/data write select
  typedef enum logic [2:0] {
    WR_NONE,
    WR_FRESH,
    WR_PREV_INS,
    WR_PREV_REM,
    WR_CUR
  } wr_sel_e;

  typedef struct packed {
    logic    load;
    logic    check;
    logic    walk;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic fail;
    logic is_remove;
    logic need_walk;
    logic walk_done;
  } dp_sts_t;

endpackage

// ===== rtl/core/ace_ctrl.sv =====
// ----------------------------------------------------------------------------
// ace_ctrl
// Sequencer for the list engine: check, predecessor walk, relink steps and
// result hand-off to the output register.
// ----------------------------------------------------------------------------
module ace_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ace_pkg::dp_sts_t  sts_i,
  output ace_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_I_RD_FREE,
    S_I_RD_PREV,
    S_I_WR_FRESH,
    S_I_WR_PREV,
    S_R_RD_PREV,
    S_R_RD_CUR,
    S_R_WR_PREV,
    S_R_WR_CUR,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.rd_sel  = ace_pkg::RD_NONE;
    cmd_o.wr_sel  = ace_pkg::WR_NONE;
    out_valid_d   = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check  = 1'b1;
        cmd_o.rd_sel = ace_pkg::RD_HEAD;
        if (sts_i.fail) begin
          state_d = S_DONE;
        end else if (sts_i.need_walk) begin
          state_d = S_WALK;
        end else if (sts_i.is_remove) begin
          state_d = S_R_RD_PREV;
        end else begin
          state_d = S_I_RD_FREE;
        end
      end
      S_WALK: begin
        cmd_o.walk   = 1'b1;
        cmd_o.rd_sel = ace_pkg::RD_WALK;
        if (sts_i.walk_done) begin
          state_d = sts_i.is_remove ? S_R_RD_PREV : S_I_RD_FREE;
        end
      end
      S_I_RD_FREE: begin
        cmd_o.rd_sel = ace_pkg::RD_FREE;
        state_d      = S_I_RD_PREV;
      end
      S_I_RD_PREV: begin
        cmd_o.rd_sel = ace_pkg::RD_PREV;
        state_d      = S_I_WR_FRESH;
      end
      S_I_WR_FRESH: begin
        cmd_o.wr_sel = ace_pkg::WR_FRESH;
        state_d      = S_I_WR_PREV;
      end
      S_I_WR_PREV: begin
        cmd_o.wr_sel = ace_pkg::WR_PREV_INS;
        state_d      = S_DONE;
      end
      S_R_RD_PREV: begin
        cmd_o.rd_sel = ace_pkg::RD_PREV;
        state_d      = S_R_RD_CUR;
      end
      S_R_RD_CUR: begin
        cmd_o.rd_sel = ace_pkg::RD_CUR;
        state_d      = S_R_WR_PREV;
      end
      S_R_WR_PREV: begin
        cmd_o.wr_sel = ace_pkg::WR_PREV_REM;
        state_d      = S_R_WR_CUR;
      end
      S_R_WR_CUR: begin
        cmd_o.wr_sel = ace_pkg::WR_CUR;
        state_d      = S_DONE;
      end
      S_DONE: begin
        // hold here while the previous result still sits in the output register
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/ace_dp.sv =====
// ----------------------------------------------------------------------------
// ace_dp
// Datapath of the list engine: item and result registers, head, free head,
// count, link and data memories with a fill mark for the reset link pattern.
// ----------------------------------------------------------------------------
module ace_dp #(
  parameter int CAPACITY  = ace_pkg::CAPACITY,
  parameter int DATA_BITS = ace_pkg::DATA_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ace_pkg::ctl_cmd_t              cmd_i,
  output ace_pkg::dp_sts_t               sts_o,
  input  logic                           opcode_i,
  input  logic [$clog2(CAPACITY+1)-1:0]  position_i,
  input  logic [DATA_BITS-1:0]           value_i,
  output logic [1:0]                     status_o,
  output logic [DATA_BITS-1:0]           removed_value_o,
  output logic [$clog2(CAPACITY+1)-1:0]  count_o
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  // out-of-range links fold to slot 0
  function automatic logic [IW-1:0] slot_of(input logic [LW-1:0] s);
    logic [IW-1:0] r;
    r = (s < CAP_L) ? s[IW-1:0] : '0;
    return r;
  endfunction

  logic [LW-1:0]        link_mem [CAPACITY];
  logic [DATA_BITS-1:0] data_mem [CAPACITY];

  logic                  op_q;
  logic [LW-1:0]         pos_q;
  logic [DATA_BITS-1:0]  val_q;
  ace_pkg::status_e      work_status_q, check_status;
  logic [DATA_BITS-1:0]  removed_q;
  logic [IW-1:0]         p_q, cur_q, raddr_q, raddr;
  logic [LW-1:0]         n_q, next_free_q;
  logic                  round_q;
  logic [IW-1:0]         head_q;
  logic [LW-1:0]         free_q, count_q, wm_q;
  logic [LW-1:0]         link_rd_q, eff;
  logic [DATA_BITS-1:0]  data_rd_q;
  ace_pkg::status_e      res_status_q;
  logic [DATA_BITS-1:0]  res_removed_q;
  logic [LW-1:0]         res_count_q;

  logic                  round_c;
  logic [IW-1:0]         fresh, waddr;
  logic                  link_we, data_we;
  logic [LW-1:0]         link_wdata;
  logic [DATA_BITS-1:0]  data_wdata;

  // slots at or above the fill mark were never written and keep the reset link
  assign eff   = (LW'(raddr_q) >= wm_q) ? (LW'(raddr_q) + LW'(1)) : link_rd_q;
  assign fresh = slot_of(free_q);

  always_comb begin
    if (op_q == ace_pkg::OP_INSERT) begin
      if (count_q >= CAP_L) begin
        check_status = ace_pkg::ST_FULL;
      end else if (pos_q > count_q) begin
        check_status = ace_pkg::ST_BADPOS;
      end else begin
        check_status = ace_pkg::ST_OK;
      end
    end else begin
      if (count_q == '0) begin
        check_status = ace_pkg::ST_EMPTY;
      end else if (pos_q >= count_q) begin
        check_status = ace_pkg::ST_BADPOS;
      end else begin
        check_status = ace_pkg::ST_OK;
      end
    end
  end

  assign round_c         = (pos_q == '0) || (pos_q == count_q);
  assign sts_o.fail      = (check_status != ace_pkg::ST_OK);
  assign sts_o.is_remove = (op_q == ace_pkg::OP_REMOVE);
  assign sts_o.need_walk = (count_q > LW'(1)) && (round_c || (pos_q > LW'(1)));
  assign sts_o.walk_done = round_q ? ((eff == LW'(head_q)) || (n_q == LW'(1)))
                                   : (n_q == LW'(1));

  always_comb begin
    case (cmd_i.rd_sel)
      ace_pkg::RD_HEAD: raddr = head_q;
      ace_pkg::RD_WALK: raddr = slot_of(eff);
      ace_pkg::RD_FREE: raddr = fresh;
      ace_pkg::RD_PREV: raddr = p_q;
      ace_pkg::RD_CUR:  raddr = slot_of(eff);
      default:          raddr = raddr_q;
    endcase
  end

  always_comb begin
    link_we    = 1'b0;
    data_we    = 1'b0;
    waddr      = p_q;
    link_wdata = eff;
    data_wdata = val_q;
    case (cmd_i.wr_sel)
      ace_pkg::WR_FRESH: begin
        link_we = 1'b1;
        data_we = 1'b1;
        waddr   = fresh;
      end
      ace_pkg::WR_PREV_INS: begin
        link_we    = 1'b1;
        link_wdata = LW'(fresh);
      end
      ace_pkg::WR_PREV_REM: begin
        link_we = 1'b1;
      end
      ace_pkg::WR_CUR: begin
        link_we    = 1'b1;
        data_we    = 1'b1;
        waddr      = cur_q;
        link_wdata = free_q;
        data_wdata = '0;
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[waddr] <= link_wdata;
    end
    if (data_we) begin
      data_mem[waddr] <= data_wdata;
    end
    link_rd_q <= link_mem[raddr];
    data_rd_q <= data_mem[raddr];
    raddr_q   <= raddr;
  end

  // item, walk and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (cmd_i.check) begin
      work_status_q <= check_status;
      removed_q     <= '0;
      p_q           <= head_q;
      round_q       <= round_c;
      n_q           <= round_c ? CAP_L : (pos_q - LW'(1));
    end
    if (cmd_i.walk) begin
      n_q <= n_q - LW'(1);
      if (!(round_q && (eff == LW'(head_q)))) begin
        p_q <= slot_of(eff);
      end
    end
    if (cmd_i.rd_sel == ace_pkg::RD_PREV) begin
      next_free_q <= eff;
    end
    if (cmd_i.rd_sel == ace_pkg::RD_CUR) begin
      cur_q <= slot_of(eff);
    end
    if (cmd_i.wr_sel == ace_pkg::WR_PREV_REM) begin
      removed_q <= data_rd_q;
    end
    if (cmd_i.finish) begin
      res_status_q  <= work_status_q;
      res_removed_q <= removed_q;
      res_count_q   <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      free_q  <= '0;
      count_q <= '0;
      wm_q    <= '0;
    end else begin
      case (cmd_i.wr_sel)
        ace_pkg::WR_PREV_INS: begin
          if (pos_q == '0) begin
            head_q <= fresh;
          end
          free_q  <= next_free_q;
          count_q <= count_q + LW'(1);
          if (LW'(fresh) == wm_q) begin
            wm_q <= wm_q + LW'(1);
          end
        end
        ace_pkg::WR_PREV_REM: begin
          if (pos_q == '0) begin
            head_q <= slot_of(eff);
          end
        end
        ace_pkg::WR_CUR: begin
          free_q  <= LW'(cur_q);
          count_q <= count_q - LW'(1);
        end
        default: begin
          head_q <= head_q;
        end
      endcase
    end
  end

  assign status_o        = res_status_q;
  assign removed_value_o = res_removed_q;
  assign count_o         = res_count_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_L)
    else $error("element count above capacity");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_sel == ace_pkg::WR_PREV_INS |=> count_q == $past(count_q) + LW'(1))
    else $error("insert commit did not bump count");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_sel == ace_pkg::WR_CUR |=> count_q == $past(count_q) - LW'(1))
    else $error("remove commit did not drop count");

  a_free_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != CAP_L |-> free_q < CAP_L)
    else $error("free head out of range while slots remain");

endmodule

// ===== rtl/core/array_circular_list_engine.sv =====
// ----------------------------------------------------------------------------
// array_circular_list_engine
// Circular singly linked list in a fixed slot array with a free list of
// unused slots; inserts or removes one element per beat.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  in_valid_i/in_ready_o carries opcode_i (0 insert, 1 remove),
//   position_i and value_i. output channel out_valid_o/out_ready_i carries
//   status_o (ok, full, bad position, empty), removed_value_o and count_o,
//   one result beat per input beat, in order.
//   a beat is taken only while the engine is idle. a refused beat goes from
//   the check straight to its result; an accepted insert or remove first
//   walks to its predecessor where needed (0 to CAPACITY steps, one link
//   memory read per step), then relinks in four steps, two reads and two
//   writes, on the link and data memories.
//   reset (rst_ni low, asynchronous) empties the list and frees all slots at
//   once; never-used slots are tracked by a fill mark, so no clearing pass.
//   a stalled receiver holds the result in the output register; the engine
//   takes the next beat and works on it, then waits with that result until
//   the register is free.
// ----------------------------------------------------------------------------
module array_circular_list_engine #(
  parameter int CAPACITY  = ace_pkg::CAPACITY,
  parameter int DATA_BITS = ace_pkg::DATA_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           opcode_i,
  input  logic [$clog2(CAPACITY+1)-1:0]  position_i,
  input  logic [DATA_BITS-1:0]           value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [DATA_BITS-1:0]           removed_value_o,
  output logic [$clog2(CAPACITY+1)-1:0]  count_o
);

  ace_pkg::ctl_cmd_t cmd;
  ace_pkg::dp_sts_t  sts;

  ace_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ace_dp #(
    .CAPACITY  (CAPACITY),
    .DATA_BITS (DATA_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .opcode_i        (opcode_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .count_o         (count_o)
  );

endmodule
